>>> rtl/pzc_pkg.sv
// ----------------------------------------------------------------------------
// pzc_pkg
// Shared types and constants of the polygon zone classifier.
// ----------------------------------------------------------------------------
package pzc_pkg;

    localparam int DEF_MAX_VERTICES = 8;
    localparam int DEF_ZONE_COUNT   = 4;
    localparam int DEF_COORD_WIDTH  = 32;
    localparam int ZONE_REGS        = 4;
    localparam int CFG_WIDTH        = 4;
    localparam int CFG_IDX_WIDTH    = 2;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_LOCATE = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [CFG_WIDTH-1:0] RESET_COUNT0 = 4'd4;
    localparam logic [CFG_WIDTH-1:0] RESET_COUNT1 = 4'd6;
    localparam logic [CFG_WIDTH-1:0] RESET_COUNT2 = 4'd4;
    localparam logic [CFG_WIDTH-1:0] RESET_COUNT3 = 4'd6;

    // one classified item handed from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  zone;
        logic [2:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic        first;
    } pzc_item_t;

endpackage

>>> rtl/pzc_in_if.sv
// ----------------------------------------------------------------------------
// pzc_in_if
// Input channel: valid/ready with one command beat.
// ----------------------------------------------------------------------------
interface pzc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [1:0]  zone_select;
    logic [2:0]  vertex_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        first_of_report;

    modport source (output valid, cmd, zone_select, vertex_slot, pos_x, pos_y,
                    first_of_report, input ready);
    modport sink   (input valid, cmd, zone_select, vertex_slot, pos_x, pos_y,
                    first_of_report, output ready);
endinterface

>>> rtl/pzc_out_if.sv
// ----------------------------------------------------------------------------
// pzc_out_if
// Output channel: valid/ready with one result beat.
// ----------------------------------------------------------------------------
interface pzc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] zone_found;
    logic       in_any_zone;
    logic [3:0] danger_flags;

    modport source (output valid, zone_found, in_any_zone, danger_flags, input ready);
    modport sink   (input valid, zone_found, in_any_zone, danger_flags, output ready);
endinterface

>>> rtl/pzc_queue.sv
// ----------------------------------------------------------------------------
// pzc_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module pzc_queue
    import pzc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pzc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output pzc_item_t head
);
    pzc_item_t  mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> rtl/pzc_front.sv
// ----------------------------------------------------------------------------
// pzc_front
// Accepts input beats, turns invalid vertex writes into no-ops, narrows coordinates.
// ----------------------------------------------------------------------------
module pzc_front
    import pzc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int ZONE_COUNT   = DEF_ZONE_COUNT,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
)
(
    pzc_in_if.sink    in_ch,
    input  logic      q_full,
    output logic      push,
    output pzc_item_t push_item
);
    localparam int ACTIVE = (ZONE_COUNT < ZONE_REGS) ? ZONE_COUNT : ZONE_REGS;

    logic ok_write;

    assign in_ch.ready = ~q_full;
    assign push        = in_ch.valid & ~q_full;
    assign ok_write = ({30'd0, in_ch.zone_select} < 32'(ACTIVE))
                    && ({29'd0, in_ch.vertex_slot} < 32'(MAX_VERTICES));

    always_comb
    begin
        push_item.cmd   = in_ch.cmd;
        // turn an out-of-range write into a no-op command
        if (in_ch.cmd == CMD_WRITE && !ok_write)
        begin
            push_item.cmd = CMD_NONE;
        end
        push_item.zone  = in_ch.zone_select;
        push_item.slot  = in_ch.vertex_slot;
        push_item.x     = 32'(signed'(in_ch.pos_x[COORD_WIDTH-1:0]));
        push_item.y     = 32'(signed'(in_ch.pos_y[COORD_WIDTH-1:0]));
        push_item.first = in_ch.first_of_report;
    end
endmodule

>>> rtl/pzc_back.sv
// ----------------------------------------------------------------------------
// pzc_back
// Executes items: vertex writes and edge-serial ray casting over the zones.
// ----------------------------------------------------------------------------
module pzc_back
    import pzc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int ZONE_COUNT   = DEF_ZONE_COUNT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  pzc_item_t      q_item,
    output logic           pop,
    input  logic [4*CFG_WIDTH-1:0] counts,
    pzc_out_if.source      out_ch
);
    localparam int ACTIVE = (ZONE_COUNT < ZONE_REGS) ? ZONE_COUNT : ZONE_REGS;
    localparam int SW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DEPTH  = ZONE_REGS * MAX_VERTICES;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_VERTICES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ZONE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [2:0] S_PROD = 3'd6;

    logic [63:0] vmem [DEPTH];
    logic [63:0] cur_rd_reg, pre_rd_reg;

    logic [2:0]  state_reg;
    logic [1:0]  zone_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] cur_reg;
    logic [SW-1:0] pre_reg;
    logic        inside_reg;
    logic        is_rep_reg;
    logic signed [32:0] px_reg, py_reg;
    logic [3:0]  mask_reg;
    logic [2:0]  found_reg;
    logic        oval_reg;
    logic signed [32:0] a_reg, b_reg, c_reg, d_reg;
    logic        dxneg_reg, strad_reg;
    logic signed [65:0] p1_reg, p2_reg;

    logic [CFG_WIDTH-1:0] cnt_raw;
    logic [CW-1:0] cnt_sat;
    logic signed [32:0] xc, yc, xp, yp;
    logic [AW-1:0] base;
    logic       strad;

    assign cnt_raw = counts[zone_reg*CFG_WIDTH +: CFG_WIDTH];
    assign cnt_sat = ({28'd0, cnt_raw} > 32'(MAX_VERTICES))
                   ? CW'(MAX_VERTICES) : CW'(cnt_raw);
    assign base = AW'(32'(zone_reg) * MAX_VERTICES);
    assign xc = 33'(signed'(cur_rd_reg[63:32]));
    assign yc = 33'(signed'(cur_rd_reg[31:0]));
    assign xp = 33'(signed'(pre_rd_reg[63:32]));
    assign yp = 33'(signed'(pre_rd_reg[31:0]));
    assign strad = (xc < px_reg && xp >= px_reg) || (xp < px_reg && xc >= px_reg);

    assign pop                 = q_valid && state_reg == S_IDLE && !oval_reg;
    assign out_ch.valid        = oval_reg;
    assign out_ch.zone_found   = found_reg;
    assign out_ch.in_any_zone  = (found_reg != 3'd0);
    assign out_ch.danger_flags = mask_reg;

    always_ff @(posedge clk)
    begin
        if (pop && q_item.cmd == CMD_WRITE)
        begin
            vmem[AW'(32'(q_item.zone) * MAX_VERTICES + 32'(q_item.slot))] <=
                {q_item.x, q_item.y};
        end
        cur_rd_reg <= vmem[base + AW'(cur_reg)];
        pre_rd_reg <= vmem[base + AW'(pre_reg)];
    end

    // payload pipeline of one edge test: differences in S_MUL, products in S_PROD
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            px_reg <= 33'(signed'(q_item.x));
            py_reg <= 33'(signed'(q_item.y));
        end
        a_reg     <= px_reg - xc;
        b_reg     <= yp - yc;
        c_reg     <= py_reg - yc;
        d_reg     <= xp - xc;
        dxneg_reg <= xp < xc;
        strad_reg <= strad;
        p1_reg    <= a_reg * b_reg;
        p2_reg    <= c_reg * d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            zone_reg   <= 2'd0;
            n_reg      <= '0;
            cur_reg    <= '0;
            pre_reg    <= '0;
            inside_reg <= 1'b0;
            is_rep_reg <= 1'b0;
            mask_reg   <= 4'd0;
            found_reg  <= 3'd0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            if (oval_reg && out_ch.ready)
            begin
                oval_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        found_reg <= 3'd0;
                        zone_reg  <= 2'd0;
                        is_rep_reg <= (q_item.cmd == CMD_REPORT);
                        if (q_item.cmd == CMD_REPORT && q_item.first)
                        begin
                            mask_reg <= 4'd0;
                        end
                        if (q_item.cmd == CMD_LOCATE || q_item.cmd == CMD_REPORT)
                        begin
                            state_reg <= S_ZONE;
                        end
                        else
                        begin
                            oval_reg <= 1'b1;
                        end
                    end
                end
                S_ZONE:
                begin
                    n_reg      <= cnt_sat;
                    cur_reg    <= '0;
                    pre_reg    <= SW'(cnt_sat - CW'(1));
                    inside_reg <= 1'b0;
                    state_reg  <= (cnt_sat == '0) ? S_DONE : S_RD;
                end
                S_RD:   state_reg <= S_MUL;
                S_MUL:  state_reg <= S_PROD;
                S_PROD: state_reg <= S_CMP;
                S_CMP:
                begin
                    // crossing above point toggles; on the edge hits at once
                    if (strad_reg && p1_reg == p2_reg)
                    begin
                        inside_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        if (strad_reg && ((p1_reg > p2_reg) != dxneg_reg))
                        begin
                            inside_reg <= ~inside_reg;
                        end
                        pre_reg <= SW'(cur_reg);
                        cur_reg <= cur_reg + CW'(1);
                        state_reg <= (cur_reg + CW'(1) == n_reg) ? S_DONE : S_RD;
                    end
                end
                S_DONE:
                begin
                    if (inside_reg && n_reg != '0)
                    begin
                        found_reg <= 3'(zone_reg) + 3'd1;
                        if (is_rep_reg)
                        begin
                            mask_reg <= mask_reg | (4'd1 << zone_reg);
                        end
                        oval_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (32'(zone_reg) + 1 < ACTIVE)
                    begin
                        zone_reg  <= zone_reg + 2'd1;
                        n_reg     <= '0;
                        state_reg <= S_ZONE;
                    end
                    else
                    begin
                        oval_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/polygon_zone_classifier.sv
// ----------------------------------------------------------------------------
// polygon_zone_classifier
// Point-in-polygon zone lookup over four stored polygons.
// ----------------------------------------------------------------------------
// Use: items enter on in_ch (valid/ready); each gives exactly one result beat
// on out_ch. A vertex write or an unknown command is answered once the back
// pops it from the queue. A locate or report walks each zone edge by edge
// through the vertex memory in read, subtract, multiply and compare steps
// on the single shared edge-test unit; a hit ends the walk early.
// Items run one at a time in the back; a front stage and a two entry queue
// take beats while the back works. Configuration (vertex counts) is to be
// written on cfg_we/cfg_index/cfg_data only while idle; the block itself does
// not enforce this. Reset clears the danger flags, the counts to 4/6/4/6 and
// the queue; vertex memory is undefined until written. A stalled receiver
// holds the result, and the back part waits; the queue then fills and
// in_ch.ready drops.
// ----------------------------------------------------------------------------
module polygon_zone_classifier
    import pzc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int ZONE_COUNT   = DEF_ZONE_COUNT,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    pzc_in_if.sink                   in_ch,
    pzc_out_if.source                out_ch,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data
);
    logic [4*CFG_WIDTH-1:0] counts_reg;
    logic      push, q_full, q_valid, pop;
    pzc_item_t push_item, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= {RESET_COUNT3, RESET_COUNT2, RESET_COUNT1, RESET_COUNT0};
        end
        else if (cfg_we)
        begin
            counts_reg[cfg_index*CFG_WIDTH +: CFG_WIDTH] <= cfg_data;
        end
    end

    pzc_front #(.MAX_VERTICES(MAX_VERTICES), .ZONE_COUNT(ZONE_COUNT),
                .COORD_WIDTH(COORD_WIDTH)) u_front
    (
        .in_ch(in_ch), .q_full(q_full), .push(push), .push_item(push_item)
    );

    pzc_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
        .full(q_full), .pop(pop), .not_empty(q_valid), .head(q_head)
    );

    pzc_back #(.MAX_VERTICES(MAX_VERTICES), .ZONE_COUNT(ZONE_COUNT)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_head), .pop(pop),
        .counts(counts_reg), .out_ch(out_ch)
    );
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polygon zone classifier. Vertex tables are
// loaded first, then directed and random locate/report traffic, mixed with
// vertex rewrites and no-op commands, runs under several vertex-count
// settings. Each accepted beat is predicted by an exact ray-casting zone
// model. The results are compared in order.
module testbench;
    import pzc_pkg::*;

    localparam int  NV        = DEF_MAX_VERTICES;
    localparam int  NZ        = DEF_ZONE_COUNT;
    localparam int  PHASES    = 6;
    localparam int  PER_PHASE = 225;
    localparam longint LIMIT  = 1000000;

    logic clk;
    logic rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]     cfg_data;

    pzc_in_if  in_bus();
    pzc_out_if out_bus();

    polygon_zone_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_bus.sink),
        .out_ch    (out_bus.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        logic [2:0] zone_found;
        logic       in_any;
        logic [3:0] flags;
    } zone_result_t;

    pzc_item_t    pending_items[$];
    zone_result_t expected_results[$];

    // predictor state
    logic signed [31:0] vx[NZ*NV];
    logic signed [31:0] vy[NZ*NV];
    logic [3:0]         zone_counts[4];
    logic [3:0]         danger_state;

    int     errors;
    longint cycles;
    int     accepted_total;
    bit     in_accepted;
    int     burst_left;
    int     gap_left;
    int     hold_left;
    bit     hold_done;
    logic [15:0] ready_pattern;
    int     pattern_pos;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic bit zone_holds(int z, logic signed [31:0] px, logic signed [31:0] py);
        int n;
        int pre;
        bit odd_cross;
        logic signed [31:0] xc, yc, xp, yp;
        logic signed [33:0] ax, ay, bx, dx;
        logic signed [67:0] lhs, rhs;
        int c;
        n = (zone_counts[z] > NV) ? NV : zone_counts[z];
        odd_cross = 1'b0;
        if (n == 0)
            return 1'b0;
        pre = n - 1;
        for (int cur = 0; cur < n; cur++)
        begin
            xc = vx[z*NV+cur]; yc = vy[z*NV+cur];
            xp = vx[z*NV+pre]; yp = vy[z*NV+pre];
            if ((xc < px && xp >= px) || (xp < px && xc >= px))
            begin
                ax = {{2{px[31]}}, px} - {{2{xc[31]}}, xc};
                ay = {{2{yp[31]}}, yp} - {{2{yc[31]}}, yc};
                bx = {{2{py[31]}}, py} - {{2{yc[31]}}, yc};
                dx = {{2{xp[31]}}, xp} - {{2{xc[31]}}, xc};
                lhs = ax * ay;
                rhs = bx * dx;
                c = (lhs > rhs) ? 1 : ((lhs == rhs) ? 0 : -1);
                if (dx < 0)
                    c = -c;
                if (c == 0)
                    return 1'b1;
                if (c > 0)
                    odd_cross = !odd_cross;
            end
            pre = cur;
        end
        return odd_cross;
    endfunction

    function automatic logic [2:0] first_zone(logic signed [31:0] px, logic signed [31:0] py);
        for (int z = 0; z < NZ && z < 4; z++)
            if (zone_holds(z, px, py))
                return 3'(z + 1);
        return 3'd0;
    endfunction

    function automatic zone_result_t classify_beat(pzc_item_t it);
        zone_result_t r;
        r.zone_found = 3'd0;
        if (it.cmd == CMD_WRITE)
        begin
            vx[it.zone*NV + it.slot] = it.x;
            vy[it.zone*NV + it.slot] = it.y;
        end
        else if (it.cmd == CMD_LOCATE)
            r.zone_found = first_zone(it.x, it.y);
        else if (it.cmd == CMD_REPORT)
        begin
            if (it.first)
                danger_state = 4'd0;
            r.zone_found = first_zone(it.x, it.y);
            if (r.zone_found != 0)
                danger_state = danger_state | (4'd1 << (r.zone_found - 1));
        end
        r.in_any = (r.zone_found != 0);
        r.flags  = danger_state;
        return r;
    endfunction

    // input acceptance, prediction, result check
    always @(posedge clk)
    begin
        zone_result_t want;
        pzc_item_t    it;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
        begin
            if (cfg_we)
                zone_counts[cfg_index] = cfg_data;
            in_accepted = in_bus.valid && in_bus.ready;
            if (in_accepted)
            begin
                it.cmd   = in_bus.cmd;
                it.zone  = in_bus.zone_select;
                it.slot  = in_bus.vertex_slot;
                it.x     = in_bus.pos_x;
                it.y     = in_bus.pos_y;
                it.first = in_bus.first_of_report;
                expected_results.push_back(classify_beat(it));
                accepted_total++;
            end
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat", out_bus.zone_found, -1);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_bus.zone_found !== want.zone_found)
                        report_mismatch("zone_found", out_bus.zone_found, want.zone_found);
                    if (out_bus.in_any_zone !== want.in_any)
                        report_mismatch("in_any_zone", out_bus.in_any_zone, want.in_any);
                    if (out_bus.danger_flags !== want.flags)
                        report_mismatch("danger_flags", out_bus.danger_flags, want.flags);
                end
            end
        end
    end

    // sender: bursts and gaps
    always @(negedge clk)
    begin
        pzc_item_t it;
        if (rst_n && (!in_bus.valid || in_accepted))
        begin
            if (gap_left > 0 || pending_items.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_bus.valid <= 1'b0;
            end
            else
            begin
                it = pending_items.pop_front();
                in_bus.valid           <= 1'b1;
                in_bus.cmd             <= it.cmd;
                in_bus.zone_select     <= it.zone;
                in_bus.vertex_slot     <= it.slot;
                in_bus.pos_x           <= it.x;
                in_bus.pos_y           <= it.y;
                in_bus.first_of_report <= it.first;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(negedge clk)
    begin
        if (!hold_done && accepted_total >= 400)
        begin
            hold_done = 1'b1;
            hold_left = 800;
        end
        if (pattern_pos == 0)
        begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
        end
        pattern_pos = (pattern_pos + 1) % 64;
        if (hold_left > 0)
        begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end
        else
            out_bus.ready <= ready_pattern[pattern_pos % 16];
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($urandom_range(0, 32'h200000)) - 32'h100000;
        endcase
    endfunction

    function automatic pzc_item_t mk_item(logic [1:0] cmd, logic [1:0] zone, logic [2:0] slot,
                                          logic [31:0] x, logic [31:0] y, logic first);
        pzc_item_t it;
        it.cmd = cmd; it.zone = zone; it.slot = slot;
        it.x = x; it.y = y; it.first = first;
        return it;
    endfunction

    // point near stored geometry: on a vertex, an edge midpoint, on a vertex's x, or anywhere
    function automatic pzc_item_t mk_point(logic [1:0] cmd, logic first);
        int a, b;
        logic signed [32:0] sx, sy;
        logic [31:0] x, y;
        a = $urandom_range(0, NZ*NV-1);
        b = (a % NV == NV-1) ? a - (NV-1) : a + 1;
        case ($urandom_range(0, 5))
            0: begin x = vx[a]; y = vy[a]; end
            1:
            begin
                sx = ({vx[a][31], vx[a]} + {vx[b][31], vx[b]}) >>> 1;
                sy = ({vy[a][31], vy[a]} + {vy[b][31], vy[b]}) >>> 1;
                x = sx[31:0]; y = sy[31:0];
            end
            2: begin x = vx[a]; y = pick_coord(); end
            default: begin x = pick_coord(); y = pick_coord(); end
        endcase
        return mk_item(cmd, 2'($urandom), 3'($urandom), x, y, first);
    endfunction

    task automatic set_counts(logic [3:0] c0, logic [3:0] c1, logic [3:0] c2, logic [3:0] c3);
        logic [3:0] vals[4];
        vals = '{c0, c1, c2, c3};
        wait (pending_items.size() == 0 && !in_bus.valid && expected_results.size() == 0);
        repeat (5) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_WIDTH'(i);
            cfg_data  <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int made;
        int z;
        int n;
        errors = 0; cycles = 0; accepted_total = 0; in_accepted = 0;
        burst_left = 0; gap_left = 0; hold_left = 0; hold_done = 0; pattern_pos = 0;
        ready_pattern = 16'hffff;
        danger_state = 4'd0;
        zone_counts = '{RESET_COUNT0, RESET_COUNT1, RESET_COUNT2, RESET_COUNT3};
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_bus.valid = 1'b0; in_bus.cmd = CMD_WRITE; in_bus.zone_select = '0;
        in_bus.vertex_slot = '0; in_bus.pos_x = '0; in_bus.pos_y = '0;
        in_bus.first_of_report = 1'b0;
        out_bus.ready = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // load every vertex before any lookup can read one
        for (int i = 0; i < NZ*NV; i++)
            pending_items.push_back(mk_item(CMD_WRITE, 2'(i / NV), 3'(i % NV),
                                            pick_coord(), pick_coord(), 1'($urandom)));
        // square in zone 0 for corner and edge hits
        pending_items.push_back(mk_item(CMD_WRITE, 2'd0, 3'd0, -32'sd1000, -32'sd1000, 0));
        pending_items.push_back(mk_item(CMD_WRITE, 2'd0, 3'd1, 32'sd1000, -32'sd1000, 0));
        pending_items.push_back(mk_item(CMD_WRITE, 2'd0, 3'd2, 32'sd1000, 32'sd1000, 0));
        pending_items.push_back(mk_item(CMD_WRITE, 2'd0, 3'd3, -32'sd1000, 32'sd1000, 1));
        pending_items.push_back(mk_item(CMD_LOCATE, 2'd3, 3'd7, 32'sd0, 32'sd0, 0));
        pending_items.push_back(mk_item(CMD_LOCATE, 2'd0, 3'd0, 32'sd1000, 32'sd0, 1));
        pending_items.push_back(mk_item(CMD_LOCATE, 2'd0, 3'd0, 32'sd0, 32'sd1000, 0));
        pending_items.push_back(mk_item(CMD_LOCATE, 2'd0, 3'd0, -32'sd1000, -32'sd1000, 0));
        pending_items.push_back(mk_item(CMD_LOCATE, 2'd1, 3'd2, 32'h7fffffff, 32'h7fffffff, 0));
        pending_items.push_back(mk_item(CMD_LOCATE, 2'd2, 3'd5, 32'h80000000, 32'h80000000, 1));
        pending_items.push_back(mk_item(CMD_REPORT, 2'd0, 3'd0, 32'sd5, 32'sd5, 1));
        pending_items.push_back(mk_item(CMD_REPORT, 2'd0, 3'd0, 32'h80000000, 32'h7fffffff, 0));
        pending_items.push_back(mk_item(CMD_REPORT, 2'd0, 3'd0, 32'sd999, -32'sd999, 0));
        pending_items.push_back(mk_item(CMD_NONE, 2'd3, 3'd7, 32'hffffffff, 32'hffffffff, 1));
        pending_items.push_back(mk_item(CMD_REPORT, 2'd0, 3'd0, 32'sd3000, 32'sd0, 1));
        pending_items.push_back(mk_item(CMD_NONE, 2'd0, 3'd0, 32'sd0, 32'sd0, 0));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: ;
                1: set_counts(4'd3, 4'd3, 4'd3, 4'd3);
                2: set_counts(4'd8, 4'd8, 4'd8, 4'd8);
                3: set_counts(4'd0, 4'd1, 4'd2, 4'd15);
                4: set_counts(4'd15, 4'd5, 4'd8, 4'd3);
                default: set_counts(4'($urandom_range(0, 15)), 4'($urandom_range(3, 8)),
                                    4'($urandom_range(3, 8)), 4'($urandom_range(0, 15)));
            endcase
            made = 0;
            while (made < PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // redraw one polygon
                        z = $urandom_range(0, NZ-1);
                        for (int s = 0; s < NV; s++)
                            pending_items.push_back(mk_item(CMD_WRITE, 2'(z), 3'(s),
                                pick_coord(), pick_coord(), 1'($urandom)));
                        made += NV;
                    end
                    1:
                    begin
                        pending_items.push_back(mk_point(CMD_NONE, 1'($urandom)));
                        made++;
                    end
                    2, 3, 4:
                    begin
                        pending_items.push_back(mk_point(CMD_LOCATE, 1'($urandom)));
                        made++;
                    end
                    default:
                    begin
                        n = $urandom_range(1, 6);
                        for (int k = 0; k < n; k++)
                            pending_items.push_back(mk_point(CMD_REPORT,
                                (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0)));
                        made += n;
                    end
                endcase
                // hand over in chunks so the queue never runs far ahead
                wait (pending_items.size() < 16);
            end
        end

        wait (pending_items.size() == 0 && !in_bus.valid && expected_results.size() == 0);
        repeat (150) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
